/* hw/rtl/lsa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsa_pkg
// Shared types, codes and constants of the label slot allocator.
// ----------------------------------------------------------------------------
package lsa_pkg;

	localparam int REQ_W      = 2;
	localparam int LABEL_W    = 16;
	localparam int SLOT_W     = 6;
	localparam int STALE_W    = 16;
	localparam int FRAME_W    = 32;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int ENTRY_W    = LABEL_W + SLOT_W + FRAME_W;

	localparam int DEF_MAX_SLOTS     = 32;
	localparam int DEF_TABLE_ENTRIES = 64;

	localparam logic [SLOT_W-1:0]  RST_MAX_SLOTS    = 6'd4;
	localparam logic [STALE_W-1:0] RST_STALE_FRAMES = 16'd5;

	typedef enum logic [REQ_W-1:0] {
		REQ_ASSIGN  = 2'd0,
		REQ_RELEASE = 2'd1,
		REQ_TICK    = 2'd2,
		REQ_NONE    = 2'd3
	} req_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_SLOTS    = 1'b0,
		CFG_STALE_FRAMES = 1'b1
	} cfg_reg_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic tick;
		logic res_one;
		logic sweep_clr;
		logic rd_en;
		logic apply_kill;
		logic refresh;
		logic scan_init;
		logic scan_step;
		logic commit;
		logic out_load;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		req_t req;
		logic ms_zero;
		logic addr_last;
		logic hit_inr;
		logic scan_done;
		logic out_free;
	} status_t;

endpackage

/* hw/rtl/lsa_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/lsa_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsa_ctrl
// Request sequencer: dispatch, table sweep, slot scan, commit, result hand-off.
// ----------------------------------------------------------------------------
module lsa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  lsa_pkg::status_t status,
	output lsa_pkg::cmd_t    cmd
);
	import lsa_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE     = 8'b0000_0001,
		ST_DISPATCH = 8'b0000_0010,
		ST_SWEEP    = 8'b0000_0100,
		ST_DRAIN    = 8'b0000_1000,
		ST_DECIDE   = 8'b0001_0000,
		ST_SCAN     = 8'b0010_0000,
		ST_COMMIT   = 8'b0100_0000,
		ST_FINISH   = 8'b1000_0000
	} state_t;

	state_t state_q, state_nxt;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				unique case (status.req)
					REQ_TICK: begin
						cmd.tick  = 1'b1;
						state_nxt = ST_FINISH;
					end
					REQ_ASSIGN: begin
						if (status.ms_zero) begin
							cmd.res_one = 1'b1;
							state_nxt   = ST_FINISH;
						end else begin
							cmd.sweep_clr = 1'b1;
							state_nxt     = ST_SWEEP;
						end
					end
					REQ_RELEASE: begin
						cmd.sweep_clr = 1'b1;
						state_nxt     = ST_SWEEP;
					end
					default: begin
						state_nxt = ST_FINISH;
					end
				endcase
			end
			ST_SWEEP: begin
				cmd.rd_en = 1'b1;
				if (status.addr_last) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// last read word is folded in at this edge
				state_nxt = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (status.req == REQ_RELEASE) begin
					cmd.apply_kill = 1'b1;
					state_nxt      = ST_FINISH;
				end else if (status.hit_inr) begin
					cmd.refresh = 1'b1;
					state_nxt   = ST_FINISH;
				end else begin
					cmd.apply_kill = 1'b1;
					cmd.scan_init  = 1'b1;
					state_nxt      = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.scan_done) begin
					state_nxt = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_nxt  = ST_FINISH;
			end
			ST_FINISH: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

/* hw/rtl/lsa_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsa_dp
// Entry table, valid bits, sweep evaluation, slot scan and result register.
// ----------------------------------------------------------------------------
module lsa_dp #(
	parameter int MAX_SLOTS     = lsa_pkg::DEF_MAX_SLOTS,
	parameter int TABLE_ENTRIES = lsa_pkg::DEF_TABLE_ENTRIES
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lsa_pkg::cmd_t                cmd,
	output lsa_pkg::status_t             status,
	input  logic [lsa_pkg::REQ_W-1:0]    req_type,
	input  logic [lsa_pkg::LABEL_W-1:0]  label,
	input  logic [lsa_pkg::SLOT_W-1:0]   max_slots,
	input  logic [lsa_pkg::STALE_W-1:0]  stale_frames,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [lsa_pkg::SLOT_W-1:0]   slot,
	output logic                         table_full
);
	import lsa_pkg::*;

	localparam int IDX_W  = $clog2(TABLE_ENTRIES);
	localparam int UIDX_W = $clog2(MAX_SLOTS + 1);
	localparam int SCAN_W = $clog2(MAX_SLOTS + 2);
	localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
	localparam logic [SLOT_W-1:0] MS_CAP   = SLOT_W'(MAX_SLOTS);
	localparam logic [SLOT_W-1:0] SLOT_ONE = SLOT_W'(1);

	// request and persistent state
	req_t                     req_q;
	logic [LABEL_W-1:0]       label_q;
	logic [FRAME_W-1:0]       frame_q;
	logic [SLOT_W-1:0]        nf_q;
	logic [TABLE_ENTRIES-1:0] valid_q;

	// sweep results
	logic [TABLE_ENTRIES-1:0] kill_q;
	logic [MAX_SLOTS:0]       used_q;
	logic [IDX_W-1:0]         addr_q;
	logic                     rd_vld_s1;
	logic [IDX_W-1:0]         idx_s1;
	logic                     hit_q;
	logic                     hit_inr_q;
	logic [IDX_W-1:0]         hit_idx_q;
	logic [SLOT_W-1:0]        hit_slot_q;
	logic                     free_found_q;
	logic [IDX_W-1:0]         free_idx_q;

	// scan and result
	logic [SCAN_W-1:0]        scan_q;
	logic [SLOT_W-1:0]        pick_q;
	logic [SLOT_W-1:0]        res_slot_q;
	logic                     res_full_q;
	logic                     out_valid_q;
	logic [SLOT_W-1:0]        out_slot_q;
	logic                     out_full_q;

	logic [SLOT_W-1:0]  ms;
	logic [ENTRY_W-1:0] rd_data;
	logic [ENTRY_W-1:0] wr_data;
	logic [IDX_W-1:0]   wr_addr;
	logic               wr_en;

	assign ms = (max_slots > MS_CAP) ? MS_CAP : max_slots;

	assign wr_en   = cmd.refresh | (cmd.commit & free_found_q);
	assign wr_addr = cmd.refresh ? hit_idx_q : free_idx_q;
	assign wr_data = cmd.refresh ? {label_q, hit_slot_q, frame_q} : {label_q, pick_q, frame_q};

	lsa_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (cmd.rd_en),
		.raddr (addr_q),
		.rdata (rd_data)
	);

	// per-entry evaluation of the word returned by the RAM
	logic [LABEL_W-1:0] e_label;
	logic [SLOT_W-1:0]  e_slot;
	logic [FRAME_W-1:0] e_seen;
	logic [FRAME_W:0]   e_limit;
	logic e_valid, e_match, e_inr, e_stale, e_kill, e_used, e_free;

	assign e_label = rd_data[ENTRY_W-1 -: LABEL_W];
	assign e_slot  = rd_data[FRAME_W +: SLOT_W];
	assign e_seen  = rd_data[FRAME_W-1:0];
	assign e_limit = {1'b0, e_seen} + {{(FRAME_W + 1 - STALE_W){1'b0}}, stale_frames};
	assign e_valid = valid_q[idx_s1];
	assign e_match = e_valid && (e_label == label_q);
	assign e_inr   = (e_slot != '0) && (e_slot <= ms);
	assign e_stale = e_valid && ({1'b0, frame_q} > e_limit);
	assign e_kill  = (req_q == REQ_RELEASE) ? e_match : ((e_match && !e_inr) || e_stale);
	assign e_used  = e_valid && !e_kill && e_inr;
	assign e_free  = !e_valid || e_kill;

	// slot scan and round-robin fallback
	logic                scan_over, scan_free;
	logic [SLOT_W-1:0]   fb_pick;
	logic [SLOT_W:0]     fb_inc;
	logic [SLOT_W-1:0]   fb_next;

	assign scan_over = (SLOT_W + 1)'(scan_q) > {1'b0, ms};
	assign scan_free = !used_q[scan_q[UIDX_W-1:0]];
	assign fb_pick   = ((nf_q == '0) || (nf_q > ms)) ? SLOT_ONE : nf_q;
	assign fb_inc    = {1'b0, fb_pick} + 1'b1;
	assign fb_next   = (fb_inc > {1'b0, ms}) ? SLOT_ONE : fb_inc[SLOT_W-1:0];

	always_comb begin
		status           = '0;
		status.req       = req_q;
		status.ms_zero   = (ms == '0);
		status.addr_last = (addr_q == LAST_IDX);
		status.hit_inr   = hit_q && hit_inr_q;
		status.scan_done = scan_over || scan_free;
		status.out_free  = !out_valid_q || out_ready;
	end

	// sweep bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q       <= '0;
			rd_vld_s1    <= 1'b0;
			idx_s1       <= '0;
			kill_q       <= '0;
			used_q       <= '0;
			hit_q        <= 1'b0;
			hit_inr_q    <= 1'b0;
			hit_idx_q    <= '0;
			hit_slot_q   <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
		end else begin
			rd_vld_s1 <= cmd.rd_en;
			idx_s1    <= addr_q;
			if (cmd.sweep_clr) begin
				addr_q       <= '0;
				kill_q       <= '0;
				used_q       <= '0;
				hit_q        <= 1'b0;
				free_found_q <= 1'b0;
			end else begin
				if (cmd.rd_en) begin
					addr_q <= addr_q + 1'b1;
				end
				if (rd_vld_s1) begin
					kill_q[idx_s1] <= e_kill;
					if (e_used) begin
						used_q[e_slot[UIDX_W-1:0]] <= 1'b1;
					end
					if (e_match && !hit_q) begin
						hit_q      <= 1'b1;
						hit_inr_q  <= e_inr;
						hit_idx_q  <= idx_s1;
						hit_slot_q <= e_slot;
					end
					if (e_free && !free_found_q) begin
						free_found_q <= 1'b1;
						free_idx_q   <= idx_s1;
					end
				end
			end
		end
	end

	// table state, frame counter, fallback pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			frame_q <= '0;
			nf_q    <= SLOT_ONE;
		end else begin
			if (cmd.apply_kill) begin
				valid_q <= valid_q & ~kill_q;
			end else if (cmd.commit && free_found_q) begin
				valid_q[free_idx_q] <= 1'b1;
			end
			if (cmd.tick && (frame_q != '1)) begin
				frame_q <= frame_q + 1'b1;
			end
			if (cmd.scan_step && scan_over) begin
				nf_q <= fb_next;
			end
		end
	end

	// request, scan and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q       <= REQ_NONE;
			label_q     <= '0;
			scan_q      <= '0;
			pick_q      <= '0;
			res_slot_q  <= '0;
			res_full_q  <= 1'b0;
			out_valid_q <= 1'b0;
			out_slot_q  <= '0;
			out_full_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				req_q      <= req_t'(req_type);
				label_q    <= label;
				res_slot_q <= '0;
				res_full_q <= 1'b0;
			end
			if (cmd.res_one) begin
				res_slot_q <= SLOT_ONE;
			end
			if (cmd.refresh) begin
				res_slot_q <= hit_slot_q;
			end
			if (cmd.scan_init) begin
				scan_q <= SCAN_W'(1);
			end else if (cmd.scan_step) begin
				if (scan_over) begin
					pick_q <= fb_pick;
				end else if (scan_free) begin
					pick_q <= SLOT_W'(scan_q);
				end else begin
					scan_q <= scan_q + 1'b1;
				end
			end
			if (cmd.commit) begin
				res_slot_q <= pick_q;
				res_full_q <= !free_found_q;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
				out_slot_q  <= res_slot_q;
				out_full_q  <= res_full_q;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign slot       = out_slot_q;
	assign table_full = out_full_q;

	// a result never names a slot beyond the build limit
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_slot_q <= MS_CAP))
		else $error("result slot out of range");

	// no free entry found means every entry is live at commit
	a_full_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && !free_found_q) |-> (&valid_q))
		else $error("table_full with a free entry");

	// fallback pointer stays inside 1..MAX_SLOTS
	a_nf_range: assert property (@(posedge clk) disable iff (!arst_n)
		(nf_q != '0) && (nf_q <= MS_CAP))
		else $error("fallback pointer out of range");

	// a refresh only follows an in-range hit
	a_refresh_hit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.refresh |-> (hit_q && hit_inr_q && (req_q == REQ_ASSIGN)))
		else $error("refresh without in-range hit");

endmodule

/* hw/rtl/label_slot_allocator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// label_slot_allocator_top
// Maps tracker labels to output slots 1..min(max_slots, MAX_SLOTS) with staleness eviction.
// ----------------------------------------------------------------------------
// One request is worked at a time. A tick, an unknown request or an assign
// with max_slots of zero is answered without a table sweep. An assign with
// nonzero max_slots or a release sweeps the whole entry table through one RAM
// read port, one entry a cycle. A release or a refreshed label then finishes;
// an assign that allocates adds a scan of the used-slot map, one slot a cycle,
// and then a commit step. The input is taken again as soon as the result sits
// in the output register, even if that result has not been taken yet. Entry
// valid bits live in flip-flops and are cleared by reset at once; no clearing
// pass is needed.
// ----------------------------------------------------------------------------
module label_slot_allocator_top #(
	parameter int MAX_SLOTS     = lsa_pkg::DEF_MAX_SLOTS,
	parameter int TABLE_ENTRIES = lsa_pkg::DEF_TABLE_ENTRIES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// request channel
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [lsa_pkg::REQ_W-1:0]      req_type,
	input  logic [lsa_pkg::LABEL_W-1:0]    label,
	// result channel
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [lsa_pkg::SLOT_W-1:0]     slot,
	output logic                           table_full,
	// configuration write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [lsa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lsa_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lsa_pkg::*;

	logic [SLOT_W-1:0]  max_slots_q;
	logic [STALE_W-1:0] stale_frames_q;
	cmd_t               cmd;
	status_t            status;

	// Config writes are always taken; the user must send them only while the block is idle (not enforced).
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_slots_q    <= RST_MAX_SLOTS;
			stale_frames_q <= RST_STALE_FRAMES;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_MAX_SLOTS:    max_slots_q    <= cfg_data[SLOT_W-1:0];
				CFG_STALE_FRAMES: stale_frames_q <= cfg_data[STALE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer: owns the input handshake and steps the datapath.
	lsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Datapath: entry RAM, valid bits, sweep logic, slot scan, result register.
	lsa_dp #(
		.MAX_SLOTS     (MAX_SLOTS),
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.req_type     (req_type),
		.label        (label),
		.max_slots    (max_slots_q),
		.stale_frames (stale_frames_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.slot         (slot),
		.table_full   (table_full)
	);

endmodule

/* bench/lsa_slot_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsa_slot_check
// Watches the request, result and register-write channels of the label slot
// allocator, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module lsa_slot_check #(
	parameter int MAX_SLOTS     = lsa_pkg::DEF_MAX_SLOTS,
	parameter int TABLE_ENTRIES = lsa_pkg::DEF_TABLE_ENTRIES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic [lsa_pkg::REQ_W-1:0]      req_type,
	input  logic [lsa_pkg::LABEL_W-1:0]    label,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [lsa_pkg::SLOT_W-1:0]     slot,
	input  logic                           table_full,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [lsa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lsa_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             mismatch_cnt,
	output int                             due_cnt
);

	import lsa_pkg::*;

	// shadow of the allocation table
	logic               live    [TABLE_ENTRIES];
	logic [LABEL_W-1:0] tag_of  [TABLE_ENTRIES];
	logic [SLOT_W-1:0]  slot_of [TABLE_ENTRIES];
	logic [FRAME_W-1:0] seen_at [TABLE_ENTRIES];
	logic [FRAME_W-1:0] frame_cnt;
	logic [SLOT_W-1:0]  rr_next;
	logic [SLOT_W-1:0]  slots_q;
	logic [STALE_W-1:0] stale_q;

	// expected results, oldest first
	logic [SLOT_W-1:0]  due_slot [$];
	logic               due_full [$];

	function automatic void allocate_slot(input logic [LABEL_W-1:0] tag,
		output logic [SLOT_W-1:0] pick, output logic full);
		int  lim;
		int  hit;
		int  free_ix;
		int  i;
		logic taken [MAX_SLOTS+1];
		pick    = '0;
		full    = 1'b0;
		hit     = -1;
		free_ix = -1;
		lim     = (int'(slots_q) > MAX_SLOTS) ? MAX_SLOTS : int'(slots_q);
		if (lim == 0) begin
			pick = SLOT_W'(1);
			return;
		end
		for (i = 0; i < TABLE_ENTRIES; i++)
			if (hit < 0 && live[i] && tag_of[i] == tag)
				hit = i;
		if (hit >= 0) begin
			if (slot_of[hit] >= 1 && int'(slot_of[hit]) <= lim) begin
				seen_at[hit] = frame_cnt;
				pick = slot_of[hit];
				return;
			end
			live[hit] = 1'b0;
		end
		// age out anything unseen too long; 33-bit sum so nothing wraps
		for (i = 0; i < TABLE_ENTRIES; i++)
			if (live[i] && {1'b0, frame_cnt} > {1'b0, seen_at[i]} + {17'd0, stale_q})
				live[i] = 1'b0;
		for (i = 0; i <= MAX_SLOTS; i++)
			taken[i] = 1'b0;
		for (i = 0; i < TABLE_ENTRIES; i++)
			if (live[i] && slot_of[i] >= 1 && int'(slot_of[i]) <= lim)
				taken[slot_of[i]] = 1'b1;
		for (i = lim; i >= 1; i--)
			if (!taken[i])
				pick = SLOT_W'(i);
		if (pick == 0) begin
			pick = (rr_next >= 1 && int'(rr_next) <= lim) ? rr_next : SLOT_W'(1);
			rr_next = (int'(pick) + 1 > lim) ? SLOT_W'(1) : pick + 1'b1;
		end
		for (i = TABLE_ENTRIES - 1; i >= 0; i--)
			if (!live[i])
				free_ix = i;
		if (free_ix < 0) begin
			full = 1'b1;
			return;
		end
		live[free_ix]    = 1'b1;
		tag_of[free_ix]  = tag;
		slot_of[free_ix] = pick;
		seen_at[free_ix] = frame_cnt;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		logic [SLOT_W-1:0] exp_slot;
		logic              exp_full;
		int                i;
		if (!arst_n) begin
			for (i = 0; i < TABLE_ENTRIES; i++)
				live[i] = 1'b0;
			frame_cnt = '0;
			rr_next   = SLOT_W'(1);
			slots_q   = RST_MAX_SLOTS;
			stale_q   = RST_STALE_FRAMES;
			due_slot.delete();
			due_full.delete();
			mismatch_cnt = 0;
			due_cnt      = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_slot.size() == 0) begin
					mismatch_cnt++;
					$display("%0t: result with nothing pending: slot %0d table_full %0b",
						$time, slot, table_full);
				end else begin
					exp_slot = due_slot.pop_front();
					exp_full = due_full.pop_front();
					if (slot !== exp_slot) begin
						mismatch_cnt++;
						$display("%0t: slot expected %0d, got %0d",
							$time, exp_slot, slot);
					end
					if (table_full !== exp_full) begin
						mismatch_cnt++;
						$display("%0t: table_full expected %0b, got %0b",
							$time, exp_full, table_full);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					CFG_MAX_SLOTS:    slots_q = cfg_data[SLOT_W-1:0];
					CFG_STALE_FRAMES: stale_q = cfg_data[STALE_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				exp_slot = '0;
				exp_full = 1'b0;
				case (req_t'(req_type))
					REQ_ASSIGN: allocate_slot(label, exp_slot, exp_full);
					REQ_RELEASE: begin
						for (i = 0; i < TABLE_ENTRIES; i++)
							if (live[i] && tag_of[i] == label)
								live[i] = 1'b0;
					end
					REQ_TICK: begin
						if (frame_cnt != '1)
							frame_cnt = frame_cnt + 1'b1;
					end
					default: ;
				endcase
				due_slot = {due_slot, exp_slot};
				due_full = {due_full, exp_full};
			end
			due_cnt = due_slot.size();
		end
	end

endmodule

/* bench/tb_label_slot_allocator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_label_slot_allocator_top
// Drives assign, release, tick and unknown requests into the label slot
// allocator under several register settings and idle patterns; a side
// checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_label_slot_allocator_top;

	import lsa_pkg::*;

	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 200;
	localparam int POOL_SIZE   = 128;
	// cycles with no handshake on any channel before the run is called dead
	localparam int QUIET_LIMIT = 5000;
	// trailing cycles after the last result
	localparam int TAIL_CYCLES = 250;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [REQ_W-1:0]      req_type;
	logic [LABEL_W-1:0]    label;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [SLOT_W-1:0]     slot;
	logic                  table_full;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int mismatch_cnt;
	int due_cnt;
	int tx_idle;
	int rx_idle = 83;
	int quiet;

	// labels shared across phases, so entries written under one setting
	// are looked up again under the next one
	logic [LABEL_W-1:0] label_pool [POOL_SIZE];

	label_slot_allocator_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.label      (label),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.slot       (slot),
		.table_full (table_full),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	lsa_slot_check u_slot_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.label        (label),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.slot         (slot),
		.table_full   (table_full),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatch_cnt (mismatch_cnt),
		.due_cnt      (due_cnt)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side back-pressure, redrawn every cycle
	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= rx_idle);
	end

	// watchdog: any accepted item on any channel restarts the count
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
			    (cfg_valid && cfg_ready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("[label_slot_allocator_top] ERROR");
				$finish;
			end
		end else begin
			quiet <= 0;
		end
	end

	// Present one request. Valid is only dropped during a gap, so back to
	// back items keep it high and just swap the payload at the falling edge.
	task automatic send_req(input req_t rt, input logic [LABEL_W-1:0] tag);
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rt;
		label    <= tag;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Stop sending and wait until every expected result has come back.
	// Every request answers, so the block is idle once the count drops to 0.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (due_cnt != 0);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// mostly assigns, which is where the table logic lives
	function automatic req_t pick_req(input int tick_w, input int rel_w);
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return REQ_NONE;
		if (r < 3 + tick_w)
			return REQ_TICK;
		if (r < 3 + tick_w + rel_w)
			return REQ_RELEASE;
		return REQ_ASSIGN;
	endfunction

	// pool labels give hits and refreshes; a few fresh ones add misses
	function automatic logic [LABEL_W-1:0] pick_label(input int pool_n);
		if ($urandom_range(0, 99) < 4)
			return LABEL_W'($urandom_range(0, 65535));
		return label_pool[$urandom_range(0, pool_n - 1)];
	endfunction

	initial begin : stimulus
		int ph;
		int n;
		int ms;
		int stale;
		int pool_n;
		int tick_w;
		int rel_w;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		req_type  = REQ_ASSIGN;
		label     = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_MAX_SLOTS;
		cfg_data  = '0;
		tx_idle   = 22;
		rx_idle   = 83;
		for (n = 0; n < POOL_SIZE; n++)
			label_pool[n] = LABEL_W'($urandom_range(0, 65535));
		label_pool[0] = '0;
		label_pool[1] = '1;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part under reset settings (4 slots, stale after 5 frames):
		// fill the slots, refresh a known label, overflow into round-robin,
		// release known and unknown labels, an unknown request, then let
		// everything go stale and reclaim it.
		send_req(REQ_ASSIGN,  16'h0000);
		send_req(REQ_ASSIGN,  16'hFFFF);
		send_req(REQ_ASSIGN,  16'h0000);
		send_req(REQ_ASSIGN,  16'h5555);
		send_req(REQ_ASSIGN,  16'hAAAA);
		send_req(REQ_ASSIGN,  16'h1234);
		send_req(REQ_ASSIGN,  16'h4321);
		send_req(REQ_RELEASE, 16'hFFFF);
		send_req(REQ_ASSIGN,  16'h0F0F);
		send_req(REQ_RELEASE, 16'hBEEF);
		send_req(REQ_NONE,    16'hFFFF);
		repeat (7)
			send_req(REQ_TICK, 16'h0000);
		send_req(REQ_ASSIGN,  16'hF0F0);
		send_req(REQ_ASSIGN,  16'h0000);
		send_req(REQ_TICK,    16'hFFFF);
		send_req(REQ_RELEASE, 16'h0000);
		send_req(REQ_NONE,    16'h0000);

		for (ph = 0; ph < PHASES; ph++) begin
			// Phase 0 fills the table past its size (no ageing, few ticks).
			// Phase 1 shrinks to one slot, so old entries fall out of range.
			// Phase 2 has zero slots; phase 3 asks for more than the block has.
			case (ph)
				0: begin
					ms = 32; stale = 65535; pool_n = 100; tick_w = 2;  rel_w = 4;
				end
				1: begin
					ms = 1;  stale = 0;     pool_n = 12;  tick_w = 20; rel_w = 10;
				end
				2: begin
					ms = 0;  stale = 3;     pool_n = 20;  tick_w = 15; rel_w = 10;
				end
				3: begin
					ms = 63; stale = 2;     pool_n = 40;  tick_w = 15; rel_w = 10;
				end
				4: begin
					ms = 7;  stale = 65535; pool_n = 24;  tick_w = 10; rel_w = 15;
				end
				5: begin
					ms = 16; stale = 10;    pool_n = 48;  tick_w = 15; rel_w = 12;
				end
				6: begin
					ms = 2;  stale = 1;     pool_n = 8;   tick_w = 25; rel_w = 10;
				end
				default: begin
					ms = 4;  stale = 5;     pool_n = 30;  tick_w = 20; rel_w = 15;
				end
			endcase
			// idle pattern: slow receiver, then slow sender, then full speed
			if (ph < 3) begin
				tx_idle = 22;
				rx_idle = 83;
			end else if (ph < 6) begin
				tx_idle = 83;
				rx_idle = 22;
			end else begin
				tx_idle = 0;
				rx_idle = 0;
			end
			settle();
			write_reg(CFG_MAX_SLOTS, CFG_DATA_W'(ms));
			write_reg(CFG_STALE_FRAMES, CFG_DATA_W'(stale));
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// hold off mid-phase until the pipe is empty
				if (n == PHASE_ITEMS / 2)
					settle();
				send_req(pick_req(tick_w, rel_w), pick_label(pool_n));
			end
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0 && due_cnt == 0)
			$display("[label_slot_allocator_top] OK");
		else
			$display("[label_slot_allocator_top] ERROR");
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/lsa_pkg.sv
hw/rtl/lsa_ram.sv
hw/rtl/lsa_ctrl.sv
hw/rtl/lsa_dp.sv
hw/rtl/label_slot_allocator_top.sv
bench/lsa_slot_check.sv
bench/tb_label_slot_allocator_top.sv
